// ===== sv/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, codes and helpers of the tlv stream parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

   // block limit ceiling and configuration widths
   localparam logic [6:0] BLOCK_LIMIT_MAX = 7'd64;
   localparam int         CSR_DATA_W      = 16;
   localparam int         CSR_INDEX_W     = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_VALUE_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BLOCKS       = 1'd1;

   // configuration reset values
   localparam logic [15:0] MAX_VALUE_LENGTH_RST = 16'd255;
   localparam logic [6:0]  MAX_BLOCKS_RST       = 7'd64;

   // record kinds
   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   // done status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_ADDR = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

   // result queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // header and value phases
   typedef enum logic [2:0] {
      PH_ADDR_LO,
      PH_ADDR_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_VALUE
   } phase_type;

   // one result record
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] block_addr;
      logic [15:0] block_length;
      logic [7:0]  value_byte;
      logic [5:0]  block_index;
      logic        end_of_block;
      logic [1:0]  status;
      logic [6:0]  blocks_parsed;
      logic        done_last;
   } rec_type;

   // frame done record
   function automatic rec_type make_done(input logic [1:0] status,
                                         input logic [6:0] count);
      rec_type r;
      r               = '0;
      r.kind          = KIND_DONE;
      r.status        = status;
      r.blocks_parsed = count;
      r.done_last     = 1'b1;
      return r;
   endfunction

endpackage

// ===== sv/tlv_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_stream_parser
// Byte-wide parser of address/length/value blocks with per-byte records.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    data_byte, last
//  rsp       out        rsp_valid/rsp_ready    kind .. done_last (9 fields)
//  csr       in         csr_wr_en              csr_index, csr_wr_data
//
//  One request per cycle with req_ready high: each byte is decoded in the
//  cycle it is taken and its zero, one or two records go into a four-entry
//  result queue. A record can leave the cycle after its request was taken.
//  req_ready drops only while the queue holds more than two records.
//  Synchronous active-high reset clears parser and queue and resets the csrs.
// ----------------------------------------------------------------------------
module tlv_stream_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [15:0]                        rsp_block_addr,
   output logic [15:0]                        rsp_block_length,
   output logic [7:0]                         rsp_value_byte,
   output logic [5:0]                         rsp_block_index,
   output logic                               rsp_end_of_block,
   output logic [1:0]                         rsp_status,
   output logic [6:0]                         rsp_blocks_parsed,
   output logic                               rsp_done_last,
   input  logic                               csr_wr_en,
   input  logic [tsp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tsp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import tsp_pkg::*;

   // configuration
   logic [15:0] max_len_ff;
   logic [6:0]  max_blocks_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [15:0] cur_addr_ff, cur_addr_in;
   logic [15:0] cur_length_ff, cur_length_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [6:0]  blocks_done_ff, blocks_done_in;
   logic        discarding_ff, discarding_in;

   // decode helpers
   logic        fire;
   logic [6:0]  block_limit;
   logic        at_limit;
   logic [15:0] addr_full;
   logic [15:0] len_full;
   logic        len_bad;
   logic        rem_one;
   logic [6:0]  blocks_next;

   // records toward the queue
   logic [1:0]  num_recs;
   logic [1:0]  push_count;
   rec_type     rec0, rec1;
   rec_type     out_rec;
   logic        room_for_two;

   assign req_ready   = room_for_two;
   assign fire        = req_valid & req_ready;
   assign addr_full   = {req_data_byte, cur_addr_ff[7:0]};
   assign len_full    = {req_data_byte, cur_length_ff[7:0]};
   assign len_bad     = (len_full > max_len_ff);
   assign at_limit    = (blocks_done_ff >= block_limit);
   assign rem_one     = (remaining_ff == 16'd1);
   assign blocks_next = blocks_done_ff + 7'd1;
   assign push_count  = fire ? num_recs : 2'd0;

   // effective block limit, clamped to one .. ceiling
   always_comb begin
      block_limit = max_blocks_ff;
      if (max_blocks_ff == 7'd0) begin
         block_limit = 7'd1;
      end else if (max_blocks_ff > BLOCK_LIMIT_MAX) begin
         block_limit = BLOCK_LIMIT_MAX;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_VALUE_LENGTH_RST;
         max_blocks_ff <= MAX_BLOCKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MAX_VALUE_LENGTH: max_len_ff    <= csr_wr_data[15:0];
            REG_MAX_BLOCKS:       max_blocks_ff <= csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   // next parser state
   always_comb begin
      phase_in       = phase_ff;
      cur_addr_in    = cur_addr_ff;
      cur_length_in  = cur_length_ff;
      remaining_in   = remaining_ff;
      blocks_done_in = blocks_done_ff;
      discarding_in  = discarding_ff;
      if (fire) begin
         if (req_last) begin
            // every last byte restarts for the next frame
            phase_in       = PH_ADDR_LO;
            cur_addr_in    = '0;
            cur_length_in  = '0;
            remaining_in   = '0;
            blocks_done_in = '0;
            discarding_in  = 1'b0;
         end else if (!discarding_ff) begin
            case (phase_ff)
               PH_ADDR_LO: begin
                  if (!at_limit) begin
                     cur_addr_in = {8'd0, req_data_byte};
                     phase_in    = PH_ADDR_HI;
                  end
               end
               PH_ADDR_HI: begin
                  if (addr_full == 16'd0) begin
                     discarding_in = 1'b1;
                  end else begin
                     cur_addr_in = addr_full;
                     phase_in    = PH_LEN_LO;
                  end
               end
               PH_LEN_LO: begin
                  cur_length_in = {8'd0, req_data_byte};
                  phase_in      = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  if (len_bad) begin
                     discarding_in = 1'b1;
                  end else if (len_full == 16'd0) begin
                     cur_length_in  = '0;
                     blocks_done_in = blocks_next;
                     phase_in       = PH_ADDR_LO;
                  end else begin
                     cur_length_in = len_full;
                     remaining_in  = len_full;
                     phase_in      = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (remaining_ff == 16'd0) begin
                     phase_in = PH_ADDR_LO;
                  end else begin
                     remaining_in = remaining_ff - 16'd1;
                     if (rem_one) begin
                        blocks_done_in = blocks_next;
                        phase_in       = PH_ADDR_LO;
                     end
                  end
               end
               default: phase_in = PH_ADDR_LO;
            endcase
         end
      end
   end

   // records caused by the current request
   always_comb begin
      num_recs = 2'd0;
      rec0     = '0;
      rec1     = '0;
      if (!discarding_ff) begin
         case (phase_ff)
            PH_ADDR_LO, PH_LEN_LO: begin
               if (req_last) begin
                  rec0     = make_done(STATUS_OK, blocks_done_ff);
                  num_recs = 2'd1;
               end
            end
            PH_ADDR_HI: begin
               if (addr_full == 16'd0) begin
                  rec0     = make_done(STATUS_ZERO_ADDR, blocks_done_ff);
                  num_recs = 2'd1;
               end else if (req_last) begin
                  rec0     = make_done(STATUS_OK, blocks_done_ff);
                  num_recs = 2'd1;
               end
            end
            PH_LEN_HI: begin
               if (len_bad) begin
                  rec0     = make_done(STATUS_BAD_LEN, blocks_done_ff);
                  num_recs = 2'd1;
               end else if (len_full == 16'd0) begin
                  // empty block, then the done record on a last byte
                  rec0.kind         = KIND_EMPTY;
                  rec0.block_addr   = cur_addr_ff;
                  rec0.block_index  = blocks_done_ff[5:0];
                  rec0.end_of_block = 1'b1;
                  num_recs          = 2'd1;
                  if (req_last) begin
                     rec1     = make_done(STATUS_OK, blocks_next);
                     num_recs = 2'd2;
                  end
               end else if (req_last) begin
                  rec0     = make_done(STATUS_BAD_LEN, blocks_done_ff);
                  num_recs = 2'd1;
               end
            end
            PH_VALUE: begin
               if (remaining_ff == 16'd0) begin
                  if (req_last) begin
                     rec0     = make_done(STATUS_OK, blocks_done_ff);
                     num_recs = 2'd1;
                  end
               end else begin
                  rec0.kind         = KIND_VALUE;
                  rec0.block_addr   = cur_addr_ff;
                  rec0.block_length = cur_length_ff;
                  rec0.value_byte   = req_data_byte;
                  rec0.block_index  = blocks_done_ff[5:0];
                  rec0.end_of_block = rem_one;
                  num_recs          = 2'd1;
                  // a last byte inside the value truncates it
                  if (req_last) begin
                     rec1     = rem_one ? make_done(STATUS_OK, blocks_next)
                                        : make_done(STATUS_BAD_LEN, blocks_done_ff);
                     num_recs = 2'd2;
                  end
               end
            end
            default: num_recs = 2'd0;
         endcase
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_ADDR_LO;
         cur_addr_ff    <= '0;
         cur_length_ff  <= '0;
         remaining_ff   <= '0;
         blocks_done_ff <= '0;
         discarding_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         cur_addr_ff    <= cur_addr_in;
         cur_length_ff  <= cur_length_in;
         remaining_ff   <= remaining_in;
         blocks_done_ff <= blocks_done_in;
         discarding_ff  <= discarding_in;
      end
   end

   // result queue
   tsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_rec0    (rec0),
      .push_rec1    (rec1),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_rec      (out_rec)
   );

   assign rsp_kind          = out_rec.kind;
   assign rsp_block_addr    = out_rec.block_addr;
   assign rsp_block_length  = out_rec.block_length;
   assign rsp_value_byte    = out_rec.value_byte;
   assign rsp_block_index   = out_rec.block_index;
   assign rsp_end_of_block  = out_rec.end_of_block;
   assign rsp_status        = out_rec.status;
   assign rsp_blocks_parsed = out_rec.blocks_parsed;
   assign rsp_done_last     = out_rec.done_last;

endmodule

// ===== sv/tsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_queue
// Small result queue: up to two records in per cycle, one out if out_ready.
// ----------------------------------------------------------------------------
module tsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  tsp_pkg::rec_type push_rec0,
   input  tsp_pkg::rec_type push_rec1,
   output logic             room_for_two,
   output logic             out_valid,
   input  logic             out_ready,
   output tsp_pkg::rec_type out_rec
);
   import tsp_pkg::*;

   rec_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     pop;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_next;

   assign pop          = out_valid & out_ready;
   assign out_valid    = (count_ff != '0);
   assign out_rec      = mem_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign wr_ptr_next  = wr_ptr_ff + QUEUE_PTR_W'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // record storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_rec0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_rec1;
      end
   end

endmodule

// ===== sv/tsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tlv stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_value_byte,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_blocks_parsed,
   input logic        rsp_done_last
);
   import tsp_pkg::*;

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // requests are taken right after reset
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   // done record and done flag travel together
   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_DONE) == rsp_done_last))
      else $error("done flag does not match record kind");

   // status and count only on done records
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_last)
         |-> (rsp_status == STATUS_OK && rsp_blocks_parsed == 7'd0))
      else $error("status or count on a non-done record");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)
                                     && $stable(rsp_value_byte)))
      else $error("stalled response changed");

endmodule

bind tlv_stream_parser tsp_checker u_tsp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_value_byte    (rsp_value_byte),
   .rsp_status        (rsp_status),
   .rsp_blocks_parsed (rsp_blocks_parsed),
   .rsp_done_last     (rsp_done_last)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tlv_stream_parser. Frames are pushed in byte by
// byte with random bursts and gaps while the result side stalls on its own
// pattern. A predictor follows each accepted request and queues the records
// it should cause; every record that leaves the block is checked field by
// field against the oldest one queued.
// ----------------------------------------------------------------------------
module tb;
   import tsp_pkg::*;

   localparam int SETTLE_CYCLES = 8;

   typedef enum {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_type;

   // clock, reset and block inputs
   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_last      = 1'b0;
   logic                   rsp_ready     = 1'b0;
   logic                   csr_wr_en     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = REG_MAX_VALUE_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_wr_data   = '0;

   // block outputs
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_block_addr;
   logic [15:0] rsp_block_length;
   logic [7:0]  rsp_value_byte;
   logic [5:0]  rsp_block_index;
   logic        rsp_end_of_block;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_blocks_parsed;
   logic        rsp_done_last;

   // predictor state and its copy of the registers
   phase_type   parse_phase = PH_ADDR_LO;
   logic [15:0] hdr_addr    = '0;
   logic [15:0] hdr_length  = '0;
   logic [15:0] value_left  = '0;
   logic [6:0]  blocks_seen = '0;
   logic        skip_rest   = 1'b0;
   logic [15:0] cfg_max_len    = MAX_VALUE_LENGTH_RST;
   logic [6:0]  cfg_max_blocks = MAX_BLOCKS_RST;

   rec_type     records_due[$];
   logic [7:0]  frame_q[$];

   int          mismatch_count = 0;
   int          records_seen   = 0;
   int          bytes_sent     = 0;
   int          burst_left     = 0;
   int          tx_gap_max     = 0;

   // result side stall control
   rx_mode_type rx_mode     = RX_STEADY;
   int          rx_hold_len = 0;
   int          hold_count  = 0;
   logic [15:0] stall_bits  = '0;
   logic [3:0]  pattern_pos = '0;

   tlv_stream_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_block_addr    (rsp_block_addr),
      .rsp_block_length  (rsp_block_length),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_block_index   (rsp_block_index),
      .rsp_end_of_block  (rsp_end_of_block),
      .rsp_status        (rsp_status),
      .rsp_blocks_parsed (rsp_blocks_parsed),
      .rsp_done_last     (rsp_done_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall time limit
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("record %0d %s got %0h expected %0h",
                                   records_seen, name, got, want));
   endtask

   // frame boundary: parser starts over
   task automatic restart_frame();
      parse_phase = PH_ADDR_LO;
      hdr_addr    = '0;
      hdr_length  = '0;
      value_left  = '0;
      blocks_seen = '0;
      skip_rest   = 1'b0;
   endtask

   task automatic push_done(input logic [1:0] status);
      rec_type r;
      r               = '0;
      r.kind          = KIND_DONE;
      r.status        = status;
      r.blocks_parsed = blocks_seen;
      r.done_last     = 1'b1;
      records_due.push_back(r);
   endtask

   // error in the header: done now, then drop the rest of the frame
   task automatic header_error(input logic [1:0] status, input logic l);
      push_done(status);
      if (l) restart_frame();
      else skip_rest = 1'b1;
   endtask

   // predictor: one accepted byte in, its records queued
   task automatic parse_byte(input logic [7:0] b, input logic l);
      rec_type    r;
      logic [6:0] limit;
      limit = (cfg_max_blocks == 7'd0) ? 7'd1 :
              (cfg_max_blocks > BLOCK_LIMIT_MAX) ? BLOCK_LIMIT_MAX : cfg_max_blocks;
      if (skip_rest) begin
         if (l) restart_frame();
         return;
      end
      case (parse_phase)
         PH_ADDR_LO: begin
            // block limit reached: ignore until the last byte
            if (blocks_seen >= limit) begin
               if (l) begin
                  push_done(STATUS_OK);
                  restart_frame();
               end
               return;
            end
            hdr_addr    = {8'h00, b};
            parse_phase = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            hdr_addr[15:8] = b;
            if (hdr_addr == 16'd0) begin
               header_error(STATUS_ZERO_ADDR, l);
               return;
            end
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            hdr_length  = {8'h00, b};
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            hdr_length[15:8] = b;
            if (hdr_length > cfg_max_len) begin
               header_error(STATUS_BAD_LEN, l);
               return;
            end
            if (hdr_length == 16'd0) begin
               r              = '0;
               r.kind         = KIND_EMPTY;
               r.block_addr   = hdr_addr;
               r.block_index  = blocks_seen[5:0];
               r.end_of_block = 1'b1;
               records_due.push_back(r);
               blocks_seen++;
               parse_phase = PH_ADDR_LO;
            end else begin
               value_left  = hdr_length;
               parse_phase = PH_VALUE;
               // header complete but no value follows
               if (l) begin
                  push_done(STATUS_BAD_LEN);
                  restart_frame();
                  return;
               end
            end
         end
         default: begin
            r              = '0;
            r.kind         = KIND_VALUE;
            r.block_addr   = hdr_addr;
            r.block_length = hdr_length;
            r.value_byte   = b;
            r.block_index  = blocks_seen[5:0];
            r.end_of_block = (value_left == 16'd1);
            records_due.push_back(r);
            value_left--;
            if (value_left == 16'd0) begin
               blocks_seen++;
               parse_phase = PH_ADDR_LO;
            end else if (l) begin
               // value cut short by the end of the frame
               push_done(STATUS_BAD_LEN);
               restart_frame();
               return;
            end
         end
      endcase
      if (l) begin
         push_done(STATUS_OK);
         restart_frame();
      end
   endtask

   task automatic check_record();
      rec_type want;
      if (records_due.size() == 0) begin
         report_mismatch($sformatf("record %0d of kind %0d with none expected",
                                   records_seen, rsp_kind));
         records_seen++;
         return;
      end
      want = records_due.pop_front();
      compare_field("kind", rsp_kind, want.kind);
      compare_field("block_addr", rsp_block_addr, want.block_addr);
      compare_field("block_length", rsp_block_length, want.block_length);
      compare_field("value_byte", rsp_value_byte, want.value_byte);
      compare_field("block_index", rsp_block_index, want.block_index);
      compare_field("end_of_block", rsp_end_of_block, want.end_of_block);
      compare_field("status", rsp_status, want.status);
      compare_field("blocks_parsed", rsp_blocks_parsed, want.blocks_parsed);
      compare_field("done_last", rsp_done_last, want.done_last);
      records_seen++;
   endtask

   // monitor: register writes, accepted requests and records at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            if (csr_index == REG_MAX_VALUE_LENGTH) cfg_max_len = csr_wr_data;
            else if (csr_index == REG_MAX_BLOCKS) cfg_max_blocks = csr_wr_data[6:0];
         end
         if (req_valid && req_ready) parse_byte(req_data_byte, req_last);
         if (rsp_valid && rsp_ready) check_record();
      end
   end

   // result side: long hold-off on request, else a rotating stall pattern
   always @(posedge clock) begin
      if (rx_hold_len != 0) begin
         hold_count  = rx_hold_len;
         rx_hold_len = 0;
      end
      if (hold_count != 0) begin
         hold_count--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_pos == 4'd0) begin
            case (rx_mode)
               RX_STEADY: stall_bits = '0;
               RX_LIGHT:  stall_bits = 16'($urandom() & $urandom());
               default:   stall_bits = 16'($urandom() | $urandom());
            endcase
         end
         rsp_ready <= !stall_bits[pattern_pos];
         pattern_pos = pattern_pos + 4'd1;
      end
   end

   // one request, with a random gap between bursts
   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      if (tx_gap_max != 0 && burst_left == 0) begin
         gap        = $urandom_range(1, tx_gap_max);
         burst_left = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last      <= l;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) burst_left--;
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // stop sending and let every queued record come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (records_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] max_len, input logic [15:0] max_blk);
      write_reg(REG_MAX_VALUE_LENGTH, max_len);
      write_reg(REG_MAX_BLOCKS, max_blk);
   endtask

   // random frame: mostly good blocks, some errors, cuts and trailing bytes
   task automatic build_random_frame();
      int nblk;
      int sel;
      int addr;
      int len;
      int cut;
      frame_q.delete();
      nblk = $urandom_range(0, 5);
      for (int k = 0; k < nblk; k++) begin
         sel  = $urandom_range(0, 99);
         addr = (sel < 4) ? 0 : $urandom_range(1, 65535);
         if (sel >= 4 && sel < 8 && cfg_max_len != 16'hFFFF)
            len = $urandom_range(0, 1) ? int'(cfg_max_len) + 1 :
                  $urandom_range(int'(cfg_max_len) + 1, 65535);
         else if (sel < 20 || cfg_max_len == 16'd0)
            len = 0;
         else begin
            len = (sel >= 97) ? 70 : 10;
            if (len > int'(cfg_max_len)) len = int'(cfg_max_len);
            len = $urandom_range(1, len);
         end
         frame_q.push_back(addr[7:0]);
         frame_q.push_back(addr[15:8]);
         frame_q.push_back(len[7:0]);
         frame_q.push_back(len[15:8]);
         if (len <= int'(cfg_max_len))
            for (int j = 0; j < len; j++) frame_q.push_back(8'($urandom));
      end
      if (frame_q.size() > 1 && $urandom_range(0, 99) < 15) begin
         cut = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      if (frame_q.size() == 0 || $urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
   endtask

   // value records, empty block, partial header and cut value
   task automatic test_value_and_empty();
      tx_gap_max = 3;
      rx_mode    = RX_LIGHT;
      frame_q = '{8'hFF, 8'hFF, 8'h02, 8'h00, 8'h00, 8'hFF};
      send_frame();
      frame_q = '{8'h34, 8'h12, 8'h00, 8'h00};
      send_frame();
      frame_q = '{8'hAB};
      send_frame();
      frame_q = '{8'h01, 8'h00, 8'h03, 8'h00, 8'hAA};
      send_frame();
      wait_idle();
   endtask

   // zero address, over-long length and a header ending the frame
   task automatic test_error_frames();
      tx_gap_max = 2;
      rx_mode    = RX_HEAVY;
      frame_q = '{8'h00, 8'h00, 8'h55};
      send_frame();
      frame_q = '{8'h00, 8'h00};
      send_frame();
      frame_q = '{8'h01, 8'h00, 8'h00, 8'h01};
      send_frame();
      frame_q = '{8'h02, 8'h00, 8'h05, 8'h00};
      send_frame();
      wait_idle();
   endtask

   // value length register at both ends
   task automatic test_length_limits();
      write_reg(REG_MAX_VALUE_LENGTH, 16'd0);
      frame_q = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h01, 8'h00};
      send_frame();
      wait_idle();
      write_reg(REG_MAX_VALUE_LENGTH, 16'hFFFF);
      frame_q = '{8'h01, 8'h80, 8'hFF, 8'hFF, 8'h11, 8'h22};
      send_frame();
      wait_idle();
   endtask

   // block limit: one, zero acting as one, and above the ceiling
   task automatic test_block_limit();
      logic [15:0] blk_words[3];
      blk_words = '{16'hFF81, 16'h0000, 16'h007F};
      for (int w = 0; w < 3; w++) begin
         write_reg(REG_MAX_BLOCKS, blk_words[w]);
         frame_q.delete();
         repeat (w == 2 ? 65 : 2) begin
            frame_q.push_back(8'($urandom_range(1, 255)));
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'h00);
            frame_q.push_back(8'h00);
         end
         send_frame();
         wait_idle();
      end
      set_limits(MAX_VALUE_LENGTH_RST, 16'(MAX_BLOCKS_RST));
   endtask

   // results held back for a long stretch while requests keep coming
   task automatic test_backpressure();
      tx_gap_max  = 0;
      rx_mode     = RX_STEADY;
      rx_hold_len = 300;
      frame_q = '{8'h5A, 8'hC3, 8'd60, 8'h00};
      repeat (60) frame_q.push_back(8'($urandom));
      send_frame();
      wait_idle();
   endtask

   // random frames over several register settings
   task automatic test_random_frames();
      int phase_end;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_limits(16'd255, 16'd64);
            1: set_limits(16'd0, 16'd1);
            2: set_limits(16'hFFFF, 16'd127);
            3: set_limits(16'd12, 16'd3);
            4: set_limits(16'($urandom), 16'($urandom));
            5: set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(0, 127)));
            6: set_limits(16'($urandom_range(0, 300)), 16'($urandom_range(0, 127)));
            default: set_limits(16'd255, 16'd64);
         endcase
         tx_gap_max = (ph == 0) ? 0 : $urandom_range(1, 6);
         rx_mode    = rx_mode_type'(ph % 3);
         phase_end  = bytes_sent + 150;
         while (bytes_sent < phase_end) begin
            build_random_frame();
            send_frame();
            if ($urandom_range(0, 9) == 0) wait_idle();
         end
         wait_idle();
      end
   endtask

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_value_and_empty();
      test_error_frames();
      test_length_limits();
      test_block_limit();
      test_backpressure();
      test_random_frames();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
